// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions. Each macro is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every rising edge of clk
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: hw/rtl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants for the telemetry frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

  // Frame length the sender uses. Only the first STORE_BYTES bytes carry
  // decoded fields; any later data byte only enters the XOR check.
  localparam int FRAME_BYTES = 7;
  localparam int STORE_BYTES = 6;
  localparam int IDX_W       = $clog2(STORE_BYTES + 1);

  // Frame kind byte values
  localparam logic [7:0] KIND_BYTE_STATUS = 8'd192;
  localparam logic [7:0] KIND_BYTE_LIMITS = 8'd193;
  localparam logic [7:0] KIND_BYTE_HALL   = 8'd194;

  // Decoded frame kind
  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_LIMITS  = 2'd1,
    KIND_HALL    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } frame_kind_t;

  typedef logic [STORE_BYTES-1:0][7:0] store_t;

  // One decoded result word
  typedef struct packed {
    logic        frame_ok;
    frame_kind_t frame_kind;
    logic [9:0]  steer_level;
    logic [11:0] value_a;
    logic [11:0] value_b;
    logic [9:0]  value_c;
    logic [7:0]  mode_flags;
    logic        current_direction;
    logic        lamp_on;
  } tfd_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/telemetry_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// telemetry_frame_decoder_top
// Byte stream in, one decoded telemetry record out per frame.
// ----------------------------------------------------------------------------
// Accepts one byte word per clock cycle, sustained; tlast marks the checksum
// byte. A result word is presented from the result register once the checksum
// byte has left the input register (the byte is decoded out of the input
// register straight into the result register), and only for that byte. The
// input side keeps accepting while a result waits; it stalls only when a checksum
// byte sits in the input register and the result register is full and not
// being taken. The XOR check, the byte counter and the store update in the
// input-register stage set the one-byte-per-cycle rate.
`default_nettype none

`include "assert_macros.svh"

module telemetry_frame_decoder_top
  import tfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tlast,   // last_byte
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [9:0] steer_level, [21:10] value_a,
                                       // [33:22] value_b, [43:34] value_c,
                                       // [51:44] mode_flags,
                                       // [52] current_direction, [53] lamp_on,
                                       // [55:54] zero
  output logic [2:0]       out_tuser   // [0] frame_ok, [2:1] frame_kind
);

  // Input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;

  // Frame state
  store_t           store_r, store_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Result register
  logic             out_valid_r;
  tfd_result_t      out_res_r;

  logic             out_free;
  logic             s1_adv;
  logic             frame_ok;
  tfd_result_t      dec_res;

  // Handshake: a data byte always moves on, a checksum byte needs room
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // Frame check on the checksum byte
  assign frame_ok = (idx_r != '0) && (xor_r == s1_byte_r);

  tfd_decode u_decode (
    .frame_ok (frame_ok),
    .store    (store_r),
    .result   (dec_res)
  );

  // Next frame state
  always_comb begin
    store_nxt = store_r;
    xor_nxt   = xor_r;
    idx_nxt   = idx_r;
    if (s1_adv) begin
      if (idx_r == '0) begin
        store_nxt = '0;
      end
      if (s1_last_r) begin
        xor_nxt = '0;
        idx_nxt = '0;
      end else begin
        if (idx_r < IDX_W'(STORE_BYTES)) begin
          store_nxt[idx_r] = s1_byte_r;
          idx_nxt          = idx_r + 1'b1;
        end
        xor_nxt = xor_r ^ s1_byte_r;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      xor_r   <= '0;
      idx_r   <= '0;
    end else begin
      store_r <= store_nxt;
      xor_r   <= xor_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
    end
    if (s1_adv && s1_last_r) begin
      out_res_r <= dec_res;
    end
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_res_r.frame_kind, out_res_r.frame_ok};
  assign out_tdata  = {2'b00,
                       out_res_r.lamp_on,
                       out_res_r.current_direction,
                       out_res_r.mode_flags,
                       out_res_r.value_c,
                       out_res_r.value_b,
                       out_res_r.value_a,
                       out_res_r.steer_level};

  // Checks
  `ASSERT_SYNC(a_bad_frame_zero, (out_valid_r && !out_res_r.frame_ok) |-> (out_tdata == '0 && out_res_r.frame_kind == KIND_UNKNOWN), "bad frame carries nonzero fields")
  `ASSERT_SYNC(a_frame_restart, (s1_adv && s1_last_r) |=> (idx_r == '0 && xor_r == '0), "frame state not cleared after checksum byte")
  `ASSERT_SYNC(a_data_no_result, (s1_adv && !s1_last_r && out_free) |=> !out_valid_r, "result produced for a data byte")
  `ASSERT_ALWAYS(a_ready_when_empty, (!out_valid_r |-> in_tready), "input stalled with empty result register")

endmodule

`default_nettype wire

// File: hw/rtl/tfd_decode.sv
// ----------------------------------------------------------------------------
// tfd_decode
// Combinational field decode of a stored frame by its kind byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_decode
  import tfd_pkg::*;
(
  input  wire logic        frame_ok,
  input  wire store_t      store,
  output tfd_result_t      result
);

  logic [7:0] b0, b1, b2, b3, b4, b5;

  assign b0 = store[0];
  assign b1 = store[1];
  assign b2 = store[2];
  assign b3 = store[3];
  assign b4 = store[4];
  assign b5 = store[5];

  // Bad frames report unknown kind with all fields zero
  always_comb begin
    result          = '0;
    result.frame_ok = frame_ok;
    result.frame_kind = KIND_UNKNOWN;
    if (frame_ok) begin
      unique case (b0)
        KIND_BYTE_STATUS: begin
          result.frame_kind        = KIND_STATUS;
          result.mode_flags        = b1;
          result.value_b           = {4'b0, b2};
          result.steer_level       = {b3, b4[7:6]};
          result.value_a           = {b4[5:0], b5[7:2]};
          result.current_direction = b5[1];
          result.lamp_on           = b5[0];
        end
        KIND_BYTE_LIMITS: begin
          result.frame_kind  = KIND_LIMITS;
          result.steer_level = {b1, b2[7:6]};
          result.value_a     = {2'b0, b2[5:0], b3[7:4]};
          result.value_b     = {2'b0, b3[3:0], b4[7:2]};
          result.value_c     = {b4[1:0], b5};
        end
        KIND_BYTE_HALL: begin
          result.frame_kind  = KIND_HALL;
          result.steer_level = {b1, b2[7:6]};
          result.value_a     = {b2[5:0], b3[7:2]};
          result.value_b     = {b3[1:0], b4, b5[7:6]};
          result.value_c     = {4'b0, b5[5:0]};
        end
        default: begin
          result.frame_kind = KIND_UNKNOWN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame decoder testbench
// Streams byte frames into the decoder and checks each decoded record against
// a behavioral model of the framing, XOR check and per-kind field unpacking.
// Directed frames are sent first, then random frames; sender gaps and receiver
// stalls are random and vary by phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tfd_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;  // [7:0] rx_byte
  logic        in_tlast   = 1'b0;  // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;          // steer, value_a, value_b, value_c, mode, dir, lamp
  logic [2:0]  out_tuser;          // [0] frame_ok, [2:1] frame_kind

  // Decoder model state
  store_t      model_store = '0;
  logic [7:0]  model_xor   = 8'd0;
  int          model_count = 0;
  tfd_result_t expected_records[$];

  int          mismatch_count = 0;
  int          bytes_sent     = 0;
  bit          sender_gaps    = 1'b1;
  int          burst_left     = 0;
  rx_mode_t    rx_mode        = RX_ALWAYS;
  int          rx_run         = 0;

  telemetry_frame_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Unpack the six stored bytes according to the frame kind
  function automatic tfd_result_t decode_record(store_t s);
    tfd_result_t r;
    r = '0;
    r.frame_kind = KIND_UNKNOWN;
    case (s[0])
      KIND_BYTE_STATUS: begin
        r.frame_kind        = KIND_STATUS;
        r.mode_flags        = s[1];
        r.value_b           = {4'd0, s[2]};
        r.steer_level       = {s[3], s[4][7:6]};
        r.value_a           = {s[4][5:0], s[5][7:2]};
        r.current_direction = s[5][1];
        r.lamp_on           = s[5][0];
      end
      KIND_BYTE_LIMITS: begin
        r.frame_kind  = KIND_LIMITS;
        r.steer_level = {s[1], s[2][7:6]};
        r.value_a     = {2'd0, s[2][5:0], s[3][7:4]};
        r.value_b     = {2'd0, s[3][3:0], s[4][7:2]};
        r.value_c     = {s[4][1:0], s[5]};
      end
      KIND_BYTE_HALL: begin
        r.frame_kind  = KIND_HALL;
        r.steer_level = {s[1], s[2][7:6]};
        r.value_a     = {s[2][5:0], s[3][7:2]};
        r.value_b     = {s[3][1:0], s[4], s[5][7:6]};
        r.value_c     = {4'd0, s[5][5:0]};
      end
      default: ;
    endcase
    return r;
  endfunction

  // Fold one accepted byte into the model; the checksum byte yields a record
  task automatic predict_byte(input logic [7:0] b, input logic last);
    tfd_result_t rec;
    if (model_count == 0) model_store = '0;
    if (!last) begin
      if (model_count < STORE_BYTES) model_store[model_count] = b;
      model_xor ^= b;
      if (model_count < 255) model_count++;
    end else begin
      rec = '0;
      rec.frame_kind = KIND_UNKNOWN;
      if (model_count >= 1 && model_xor == b) begin
        rec = decode_record(model_store);
        rec.frame_ok = 1'b1;
      end
      expected_records.push_back(rec);
      model_xor   = 8'd0;
      model_count = 0;
    end
  endtask

  // Send one byte word, with random gaps between bursts when sender_gaps is set
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  // Body bytes followed by their XOR checksum, optionally corrupted
  task automatic send_frame(input byte_q_t body, input bit bad_sum);
    logic [7:0] sum;
    sum = 8'd0;
    foreach (body[i]) begin
      send_byte(body[i], 1'b0);
      sum ^= body[i];
    end
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum, 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed frames of known kinds; some short, long, odd or corrupt
  task automatic send_random_frame();
    byte_q_t body;
    int      pick;
    int      len;
    pick = $urandom_range(0, 99);
    if (pick < 70)      len = 6;
    else if (pick < 82) len = $urandom_range(0, 5);
    else                len = $urandom_range(7, 16);
    pick = $urandom_range(0, 99);
    if (len > 0) begin
      if (pick < 28)      body.push_back(KIND_BYTE_STATUS);
      else if (pick < 56) body.push_back(KIND_BYTE_LIMITS);
      else if (pick < 84) body.push_back(KIND_BYTE_HALL);
      else                body.push_back(8'($urandom_range(0, 255)));
    end
    while (body.size() < len) body.push_back(payload_byte());
    send_frame(body, $urandom_range(0, 99) < 15);
  endtask

  task automatic test_decoded_kinds();
    send_frame('{KIND_BYTE_STATUS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);
    send_frame('{KIND_BYTE_HALL, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0);
  endtask

  // Unknown kind byte, and a limits frame that ends before its fields
  task automatic test_short_and_unknown();
    send_frame('{8'h00}, 1'b0);
    send_frame('{KIND_BYTE_LIMITS, 8'h5A}, 1'b0);
  endtask

  // Lone checksum byte, then a wrong checksum
  task automatic test_bad_frames();
    send_frame('{}, 1'b0);
    send_frame('{KIND_BYTE_STATUS}, 1'b1);
  endtask

  // Bytes past the store still feed the XOR; the byte count must not wrap
  task automatic test_long_frames();
    byte_q_t body;
    body.push_back(KIND_BYTE_STATUS);
    repeat (299) body.push_back(payload_byte());
    send_frame(body, 1'b0);
    body = '{KIND_BYTE_HALL};
    repeat (8) body.push_back(payload_byte());
    send_frame(body, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int stop_at;
    bit drained;
    sender_gaps = 1'b1;
    rx_mode     = RX_LIGHT;
    stop_at     = bytes_sent + n_bytes;
    drained     = 1'b0;
    while (bytes_sent < stop_at) begin
      send_random_frame();
      // hold off once mid-phase until the pipeline is empty
      if (!drained && bytes_sent >= stop_at - n_bytes / 2) begin
        wait_drained();
        drained = 1'b1;
      end
    end
  endtask

  task automatic test_streaming(input int n_bytes);
    int stop_at;
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    stop_at     = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  task automatic test_backpressure(input int n_bytes);
    int stop_at;
    sender_gaps = 1'b0;
    rx_mode     = RX_HEAVY;
    stop_at     = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  // Receiver ready pattern: held ready in RX_ALWAYS, else alternating ready and stall runs of random length
  always @(negedge clk) begin
    if (rx_run > 0) begin
      rx_run--;
    end else if (rx_mode == RX_ALWAYS) begin
      out_tready <= 1'b1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      rx_run = (rx_mode == RX_HEAVY) ? $urandom_range(1, 12) : $urandom_range(1, 4);
    end else begin
      out_tready <= 1'b1;
      rx_run = (rx_mode == RX_HEAVY) ? $urandom_range(1, 2) : $urandom_range(1, 8);
    end
  end

  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every accepted result word with the oldest pending record
  always @(posedge clk) begin : result_check
    tfd_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_records.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none actual tuser %h tdata %h",
                 $time, out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = expected_records.pop_front();
        check_field("frame_ok",          want.frame_ok,          out_tuser[0]);
        check_field("frame_kind",        want.frame_kind,        out_tuser[2:1]);
        check_field("steer_level",       want.steer_level,       out_tdata[9:0]);
        check_field("value_a",           want.value_a,           out_tdata[21:10]);
        check_field("value_b",           want.value_b,           out_tdata[33:22]);
        check_field("value_c",           want.value_c,           out_tdata[43:34]);
        check_field("mode_flags",        want.mode_flags,        out_tdata[51:44]);
        check_field("current_direction", want.current_direction, out_tdata[52]);
        check_field("lamp_on",           want.lamp_on,           out_tdata[53]);
      end
    end
  end

  // Main sequence
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_decoded_kinds();
    test_short_and_unknown();
    test_bad_frames();
    test_long_frames();
    test_random_traffic(380);
    test_streaming(190);
    test_backpressure(190);

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_records.size() != 0) begin
      $display("%0t ns: records left over, expected 0 actual %0d",
               $time, expected_records.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("%0t ns: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// File: telemetry_frame_decoder_top.f
+incdir+hw/rtl
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_decode.sv
hw/rtl/telemetry_frame_decoder_top.sv
dv/testbench.sv
